>>> rtl/tkhv_pkg.sv
package tkhv_pkg;

   // Longest mechanism OID that the compare logic accepts as configured.
   localparam int MaxOidBytes = 16;

   localparam logic [7:0] SeqTag = 8'h60;
   localparam logic [7:0] OidTag = 8'h06;
   localparam logic [7:0] LongFormBit = 8'h80;
   localparam logic [7:0] LongFormMask = 8'h7f;

   typedef enum logic [2:0] {
      CsrCompareMech = 3'd0,
      CsrMechOidLength = 3'd1,
      CsrMechOidLower = 3'd2,
      CsrMechOidUpper = 3'd3,
      CsrReadTokenType = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PhTag = 3'd0,
      PhLen = 3'd1,
      PhLenx = 3'd2,
      PhOidTag = 3'd3,
      PhOidLen = 3'd4,
      PhOid = 3'd5,
      PhType = 3'd6,
      PhBody = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      StOk = 2'd0,
      StDefective = 2'd1,
      StEmptyOid = 2'd2,
      StWrongMech = 2'd3
   } status_type;

   typedef struct packed {
      logic compare_mech;
      logic [4:0] mech_oid_length;
      logic [63:0] mech_oid_lower;
      logic [63:0] mech_oid_upper;
      logic read_token_type;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic [7:0] data_byte;
      logic last_byte;
   } byte_type;

endpackage

>>> rtl/tkhv_if.sv
interface tkhv_req_if;
   logic valid;
   logic ready;
   logic [7:0] data_byte;
   logic last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tkhv_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic [15:0] token_type;
   logic [30:0] body_bytes;
   logic [30:0] body_offset;
   logic [7:0] oid_length;

   modport source (output valid, output status, output token_type, output body_bytes,
                   output body_offset, output oid_length, input ready);
   modport sink (input valid, input status, input token_type, input body_bytes,
                 input body_offset, input oid_length, output ready);
endinterface

>>> rtl/token_header_verifier.sv
// Channel   Direction  Handshake      Contents
// req_chan  in         valid/ready    data_byte, last_byte
// rsp_chan  out        valid/ready    status, token_type, body_bytes, body_offset, oid_length
// csr_*     in         write enable   csr_index, csr_write_data (64 bits)
//
// One request is taken per cycle while the response side does not stall; a byte
// is held in the input register until its parse step writes the result register,
// and a response is offered from the result register once the last byte of its token has passed that step.
// Only the last byte of a token produces a response.
// A stalled response holds the parse stage; the input register still takes
// one request, after which the request side stalls too.
// Reset is synchronous and restores the register defaults and the parse state.
module token_header_verifier (
   input logic clock,
   input logic reset,
   tkhv_req_if.sink req_chan,
   tkhv_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input logic [2:0] csr_index,
   input logic [63:0] csr_write_data
);
   import tkhv_pkg::*;

   cfg_type cfg;
   byte_type in_byte;
   logic advance;

   tkhv_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cfg(cfg)
   );

   tkhv_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .advance(advance),
      .in_byte(in_byte)
   );

   tkhv_parser u_parser (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .in_byte(in_byte),
      .advance(advance),
      .rsp_chan(rsp_chan)
   );

endmodule

>>> rtl/tkhv_csr.sv
module tkhv_csr (
   input logic clock,
   input logic reset,
   input logic csr_write_enable,
   input logic [2:0] csr_index,
   input logic [63:0] csr_write_data,
   output tkhv_pkg::cfg_type cfg
);
   import tkhv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CsrCompareMech: cfg_in.compare_mech = csr_write_data[0];
            CsrMechOidLength: cfg_in.mech_oid_length = csr_write_data[4:0];
            CsrMechOidLower: cfg_in.mech_oid_lower = csr_write_data;
            CsrMechOidUpper: cfg_in.mech_oid_upper = csr_write_data;
            CsrReadTokenType: cfg_in.read_token_type = csr_write_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         cfg_ff.compare_mech <= 1'b1;
         cfg_ff.read_token_type <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/tkhv_in_stage.sv
module tkhv_in_stage (
   input logic clock,
   input logic reset,
   tkhv_req_if.sink req_chan,
   input logic advance,
   output tkhv_pkg::byte_type in_byte
);
   import tkhv_pkg::*;

   byte_type byte_ff;
   byte_type byte_in;
   logic take;

   assign req_chan.ready = !byte_ff.valid || advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      byte_in = byte_ff;
      if (take) begin
         byte_in.valid = 1'b1;
         byte_in.data_byte = req_chan.data_byte;
         byte_in.last_byte = req_chan.last_byte;
      end else if (advance) begin
         byte_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff.valid <= 1'b0;
      end else begin
         byte_ff.valid <= byte_in.valid;
      end
      byte_ff.data_byte <= byte_in.data_byte;
      byte_ff.last_byte <= byte_in.last_byte;
   end

   assign in_byte = byte_ff;

endmodule

>>> rtl/tkhv_parser.sv
module tkhv_parser (
   input logic clock,
   input logic reset,
   input tkhv_pkg::cfg_type cfg,
   input tkhv_pkg::byte_type in_byte,
   output logic advance,
   tkhv_rsp_if.source rsp_chan
);
   import tkhv_pkg::*;

   phase_type phase_ff, phase_in;
   logic [31:0] byte_index_ff, byte_index_in;
   logic [2:0] len_left_ff, len_left_in;
   logic [31:0] declared_ff, declared_in;
   logic [31:0] len_end_ff, len_end_in;
   logic [7:0] seen_oid_ff, seen_oid_in;
   logic [7:0] oid_left_ff, oid_left_in;
   logic mismatch_ff, mismatch_in;
   logic struct_err_ff, struct_err_in;
   logic [15:0] type_ff, type_in;
   logic [31:0] header_end_ff, header_end_in;

   logic rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic [15:0] token_type_ff, token_type_in;
   logic [30:0] body_bytes_ff, body_bytes_in;
   logic [30:0] body_offset_ff, body_offset_in;
   logic [7:0] oid_length_ff, oid_length_in;

   logic [7:0] b;
   logic [31:0] cur_next;
   logic [6:0] n_octets;
   logic [7:0] oid_pos;
   logic [15:0][7:0] oid_bytes;
   logic [32:0] total;
   logic [32:0] span;
   logic [32:0] body_span;
   logic [31:0] declared_shift;
   logic [2:0] len_dec;
   logic [7:0] oid_dec;
   logic ending;

   assign advance = in_byte.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign ending = advance && in_byte.last_byte;
   assign b = in_byte.data_byte;
   assign cur_next = byte_index_ff + 32'd1;
   assign n_octets = b[6:0] & LongFormMask[6:0];
   assign oid_pos = seen_oid_ff - oid_left_ff;
   assign oid_bytes = {cfg.mech_oid_upper, cfg.mech_oid_lower};
   assign declared_shift = {declared_ff[23:0], b};
   assign len_dec = len_left_ff - 3'd1;
   assign oid_dec = oid_left_ff - 8'd1;

   // Parse step for one byte; the end of the OID either opens the token type
   // field or closes the header right here.
   always_comb begin
      phase_in = phase_ff;
      len_left_in = len_left_ff;
      declared_in = declared_ff;
      len_end_in = len_end_ff;
      seen_oid_in = seen_oid_ff;
      oid_left_in = oid_left_ff;
      mismatch_in = mismatch_ff;
      struct_err_in = struct_err_ff;
      type_in = type_ff;
      header_end_in = header_end_ff;
      case (phase_ff)
         PhTag: begin
            if (b != SeqTag) begin
               struct_err_in = 1'b1;
               phase_in = PhBody;
            end else begin
               phase_in = PhLen;
            end
         end
         PhLen: begin
            if ((b & LongFormBit) != 8'd0) begin
               declared_in = '0;
               if (n_octets > 7'd4) begin
                  struct_err_in = 1'b1;
                  phase_in = PhBody;
               end else if (n_octets == 7'd0) begin
                  len_end_in = cur_next;
                  phase_in = PhOidTag;
               end else begin
                  len_left_in = n_octets[2:0];
                  phase_in = PhLenx;
               end
            end else begin
               declared_in = {24'd0, b};
               len_end_in = cur_next;
               phase_in = PhOidTag;
            end
         end
         PhLenx: begin
            declared_in = declared_shift;
            len_left_in = len_dec;
            if (len_dec == 3'd0) begin
               if (declared_shift[31]) begin
                  struct_err_in = 1'b1;
                  phase_in = PhBody;
               end else begin
                  len_end_in = cur_next;
                  phase_in = PhOidTag;
               end
            end
         end
         PhOidTag: begin
            if (b != OidTag) begin
               struct_err_in = 1'b1;
               phase_in = PhBody;
            end else begin
               phase_in = PhOidLen;
            end
         end
         PhOidLen: begin
            seen_oid_in = b;
            oid_left_in = b;
            mismatch_in = (b != {3'd0, cfg.mech_oid_length})
               || ({3'd0, cfg.mech_oid_length} > 8'(MaxOidBytes));
            if (b == 8'd0) begin
               if (cfg.read_token_type) begin
                  phase_in = PhType;
                  len_left_in = 3'd2;
                  type_in = '0;
               end else begin
                  header_end_in = cur_next;
                  phase_in = PhBody;
               end
            end else begin
               phase_in = PhOid;
            end
         end
         PhOid: begin
            if (oid_pos > 8'd15 || oid_bytes[oid_pos[3:0]] != b) begin
               mismatch_in = 1'b1;
            end
            oid_left_in = oid_dec;
            if (oid_dec == 8'd0) begin
               if (cfg.read_token_type) begin
                  phase_in = PhType;
                  len_left_in = 3'd2;
                  type_in = '0;
               end else begin
                  header_end_in = cur_next;
                  phase_in = PhBody;
               end
            end
         end
         PhType: begin
            type_in = {type_ff[7:0], b};
            len_left_in = len_dec;
            if (len_dec == 3'd0) begin
               header_end_in = cur_next;
               phase_in = PhBody;
            end
         end
         default: phase_in = phase_ff;
      endcase

      byte_index_in = (byte_index_ff == '1) ? byte_index_ff : cur_next;
   end

   // Verdict on the state as it stands after the last byte.
   assign total = {1'b0, byte_index_ff} + 33'd1;
   assign span = total - {1'b0, len_end_in};
   assign body_span = total - {1'b0, header_end_in};

   always_comb begin
      if (struct_err_in || phase_in == PhTag || phase_in == PhLen || phase_in == PhLenx) begin
         status_in = StDefective;
      end else if (span != {1'b0, declared_in}) begin
         status_in = StDefective;
      end else if (phase_in == PhOidTag || phase_in == PhOidLen || phase_in == PhOid) begin
         status_in = StDefective;
      end else if (!cfg.compare_mech && seen_oid_in == 8'd0) begin
         status_in = StEmptyOid;
      end else if (cfg.compare_mech && mismatch_in) begin
         status_in = StWrongMech;
      end else if (phase_in == PhType) begin
         status_in = StDefective;
      end else begin
         status_in = StOk;
      end

      token_type_in = (status_in == StOk) ? type_in : '0;
      body_bytes_in = (status_in == StOk) ? body_span[30:0] : '0;
      body_offset_in = (status_in == StOk) ? header_end_in[30:0] : '0;
      oid_length_in = seen_oid_in;

      if (advance) begin
         rsp_valid_in = in_byte.last_byte;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ending) begin
         phase_ff <= PhTag;
         byte_index_ff <= '0;
         len_left_ff <= '0;
         declared_ff <= '0;
         len_end_ff <= '0;
         seen_oid_ff <= '0;
         oid_left_ff <= '0;
         mismatch_ff <= 1'b0;
         struct_err_ff <= 1'b0;
         type_ff <= '0;
         header_end_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         byte_index_ff <= byte_index_in;
         len_left_ff <= len_left_in;
         declared_ff <= declared_in;
         len_end_ff <= len_end_in;
         seen_oid_ff <= seen_oid_in;
         oid_left_ff <= oid_left_in;
         mismatch_ff <= mismatch_in;
         struct_err_ff <= struct_err_in;
         type_ff <= type_in;
         header_end_ff <= header_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ending) begin
         status_ff <= status_in;
         token_type_ff <= token_type_in;
         body_bytes_ff <= body_bytes_in;
         body_offset_ff <= body_offset_in;
         oid_length_ff <= oid_length_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.token_type = token_type_ff;
   assign rsp_chan.body_bytes = body_bytes_ff;
   assign rsp_chan.body_offset = body_offset_ff;
   assign rsp_chan.oid_length = oid_length_ff;

   a_verdict_restarts: assert property (@(posedge clock) disable iff (reset)
      ending |=> (rsp_valid_ff && phase_ff == PhTag && byte_index_ff == 32'd0))
      else $error("verdict did not restart the parse");

   a_lenx_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhLenx |-> (len_left_ff != 3'd0 && len_left_ff <= 3'd4))
      else $error("length octet count out of range");

   a_oid_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhOid |-> oid_left_ff != 8'd0)
      else $error("OID phase with no bytes left");

   a_type_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PhType |-> (len_left_ff == 3'd1 || len_left_ff == 3'd2))
      else $error("token type byte count out of range");

endmodule
